// ----- rtl/core/dtpw_pkg.sv -----
`default_nettype none

package dtpw_pkg;

    // frame geometry and store organization
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int CNT_W      = ADDR_W + 1;

    // fixed field widths
    localparam int CFG_W   = 9;
    localparam int COORD_W = 8;
    localparam int DEPTH_W = 24;
    localparam int COLOR_W = 32;
    localparam int OP_W    = 3;

    localparam logic [DEPTH_W-1:0] DEPTH_FAR  = '1;
    localparam logic [CNT_W-1:0]   STORE_CNT  = CNT_W'(STORE_SIZE);
    localparam logic [CFG_W-1:0]   WIDTH_CAP  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0]   HEIGHT_CAP = CFG_W'(MAX_HEIGHT);

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_PLOT        = 3'd0,
        OP_TEST_PLOT   = 3'd1,
        OP_CLEAR_COLOR = 3'd2,
        OP_RESET_DEPTH = 3'd3,
        OP_READ        = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_DECIDE,
        ST_FILL_COLOR,
        ST_FILL_DEPTH
    } t_state;

    // sequencer to datapath control
    typedef struct packed {
        logic              busy;
        logic              decide;
        logic              finish;
        logic              fill_color;
        logic              fill_depth;
        logic              fill_report;
        logic [ADDR_W-1:0] fill_addr;
    } t_seq_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/dtpw_ram.sv -----
`default_nettype none

module dtpw_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    // single port, read-first, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/dtpw_seq.sv -----
`default_nettype none

module dtpw_seq import dtpw_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire t_op              i_op,
    input  wire logic [CNT_W-1:0] i_pix_count,
    output t_seq_ctl              o_ctl
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_limit, n_limit;
    logic             r_report, n_report;
    logic             fill_last;
    logic             goes_fill_color;
    logic             goes_fill_depth;

    assign fill_last       = (r_cnt == r_limit - CNT_W'(1));
    assign goes_fill_color = (i_op == OP_CLEAR_COLOR) && (i_pix_count != '0);
    assign goes_fill_depth = (i_op == OP_RESET_DEPTH);

    // next state
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_limit  = r_limit;
        n_report = r_report;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (goes_fill_color) begin
                    n_state  = ST_FILL_COLOR;
                    n_cnt    = '0;
                    n_limit  = i_pix_count;
                    n_report = 1'b1;
                end else if (goes_fill_depth) begin
                    n_state  = ST_FILL_DEPTH;
                    n_cnt    = '0;
                    n_limit  = STORE_CNT;
                    n_report = 1'b1;
                end else if (i_accept) begin
                    n_state = ST_ACCESS;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FILL_COLOR, ST_FILL_DEPTH: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctl             = '0;
        o_ctl.fill_addr   = r_cnt[ADDR_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.busy = 1'b0;
            end
            ST_ACCESS: begin
                o_ctl.busy = 1'b1;
            end
            ST_DECIDE: begin
                o_ctl.decide = 1'b1;
                o_ctl.finish = !goes_fill_color && !goes_fill_depth;
                o_ctl.busy   = goes_fill_color || goes_fill_depth;
            end
            ST_FILL_COLOR: begin
                o_ctl.busy        = 1'b1;
                o_ctl.fill_color  = 1'b1;
                o_ctl.fill_report = fill_last && r_report;
            end
            ST_FILL_DEPTH: begin
                o_ctl.busy        = 1'b1;
                o_ctl.fill_depth  = 1'b1;
                o_ctl.fill_report = fill_last && r_report;
            end
            default: begin
                o_ctl.busy = 1'b1;
            end
        endcase
    end

    // reset starts a silent sweep of the depth store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_FILL_DEPTH;
            r_cnt    <= '0;
            r_limit  <= STORE_CNT;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_limit  <= n_limit;
            r_report <= n_report;
        end
    end

    a_access_then_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ACCESS |=> r_state == ST_DECIDE)
        else $error("access not followed by decide");

    a_fill_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL_COLOR || r_state == ST_FILL_DEPTH) |-> r_cnt < r_limit)
        else $error("fill counter past its limit");

    a_one_fill_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.fill_color && o_ctl.fill_depth))
        else $error("both fills active");

endmodule

`default_nettype wire

// ----- rtl/core/depth_tested_pixel_writer.sv -----
`default_nettype none
// Timing: a plot, depth-tested plot or read goes through access and decide once accepted; its
//   result strobe is registered out of decide. A point transaction reads the single-port stores
//   in access, then compares and writes back in decide, where a new one can be accepted; a color
//   clear sweeps width*height entries (none for an empty frame), a depth reset all 65536, one
//   store entry written per cycle. Reset: synchronous, active low; afterwards busy stays high
//   while depth is swept to the far value. The receiver cannot stall: each result is held one cycle.

module depth_tested_pixel_writer import dtpw_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [COORD_W-1:0] i_pixel_x,
    input  wire logic [COORD_W-1:0] i_pixel_y,
    input  wire logic [DEPTH_W-1:0] i_depth,
    input  wire logic [COLOR_W-1:0] i_color,
    // configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    // result channel
    output logic                    o_strobe,
    output logic                    o_written,
    output logic                    o_out_of_range,
    output logic      [COLOR_W-1:0] o_color_out,
    output logic      [DEPTH_W-1:0] o_depth_out
);

    t_seq_ctl ctl;

    // configuration registers
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    // accepted transaction
    t_op              r_op;
    logic             r_inside;
    logic [ADDR_W-1:0] r_addr;
    logic [DEPTH_W-1:0] r_depth;
    logic [COLOR_W-1:0] r_color;
    logic [CNT_W-1:0] r_pix_count;

    // result registers
    logic               r_strobe;
    logic               r_written;
    logic               r_oor;
    logic [COLOR_W-1:0] r_color_out;
    logic [DEPTH_W-1:0] r_depth_out;

    logic               accept;
    logic [CFG_W-1:0]   eff_w;
    logic [CFG_W-1:0]   eff_h;
    logic               in_frame;
    logic [COORD_W+CFG_W-1:0] row_base;
    logic [COORD_W+CFG_W-1:0] addr_full;
    logic [2*CFG_W-1:0] pix_count_full;

    logic [ADDR_W-1:0]  mem_addr;
    logic               color_we;
    logic               depth_we;
    logic [DEPTH_W-1:0] depth_wdata;
    logic [COLOR_W-1:0] rd_color;
    logic [DEPTH_W-1:0] rd_depth;
    logic               test_pass;
    logic               point_op;

    logic               n_written;
    logic               n_oor;
    logic [COLOR_W-1:0] n_color_out;
    logic [DEPTH_W-1:0] n_depth_out;

    assign busy   = ctl.busy;
    assign accept = start && !busy;

    // clamp the frame registers to the store geometry
    assign eff_w = (r_frame_width  > WIDTH_CAP)  ? WIDTH_CAP  : r_frame_width;
    assign eff_h = (r_frame_height > HEIGHT_CAP) ? HEIGHT_CAP : r_frame_height;

    assign in_frame = ({1'b0, i_pixel_x} < eff_w) && ({1'b0, i_pixel_y} < eff_h);

    // row-major address; fits the store whenever the pixel is inside the frame
    assign row_base       = i_pixel_y * eff_w;
    assign addr_full      = row_base + (COORD_W+CFG_W)'(i_pixel_x);
    assign pix_count_full = eff_w * eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(256);
            r_frame_height <= CFG_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture the transaction payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= t_op'(i_op);
            r_inside    <= in_frame;
            r_addr      <= addr_full[ADDR_W-1:0];
            r_depth     <= i_depth;
            r_color     <= i_color;
            r_pix_count <= pix_count_full[CNT_W-1:0];
        end
    end

    dtpw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (r_op),
        .i_pix_count (r_pix_count),
        .o_ctl       (ctl)
    );

    // sweeps drive the address, otherwise the transaction's pixel
    assign mem_addr  = (ctl.fill_color || ctl.fill_depth) ? ctl.fill_addr : r_addr;
    assign test_pass = (r_depth <= rd_depth);
    assign point_op  = (r_op == OP_PLOT) || (r_op == OP_TEST_PLOT) || (r_op == OP_READ);

    // write back in the decide cycle; read data was fetched in the access cycle
    assign color_we = ctl.fill_color
                   || (ctl.decide && r_inside && (r_op == OP_PLOT))
                   || (ctl.decide && r_inside && (r_op == OP_TEST_PLOT) && test_pass);
    assign depth_we = ctl.fill_depth
                   || (ctl.decide && r_inside && (r_op == OP_TEST_PLOT) && test_pass);
    assign depth_wdata = ctl.fill_depth ? DEPTH_FAR : r_depth;

    dtpw_ram #(
        .WIDTH  (COLOR_W),
        .ADDR_W (ADDR_W)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (color_we),
        .i_addr  (mem_addr),
        .i_wdata (r_color),
        .o_rdata (rd_color)
    );

    dtpw_ram #(
        .WIDTH  (DEPTH_W),
        .ADDR_W (ADDR_W)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (depth_we),
        .i_addr  (mem_addr),
        .i_wdata (depth_wdata),
        .o_rdata (rd_depth)
    );

    // result of a transaction that ends in the decide cycle
    always_comb begin
        n_written   = 1'b0;
        n_oor       = point_op && !r_inside;
        n_color_out = '0;
        n_depth_out = '0;
        case (r_op)
            OP_PLOT:        n_written = r_inside;
            OP_TEST_PLOT:   n_written = r_inside && test_pass;
            OP_CLEAR_COLOR: n_written = 1'b1;   // empty frame: nothing to sweep
            OP_READ: begin
                if (r_inside) begin
                    n_color_out = rd_color;
                    n_depth_out = rd_depth;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ctl.finish || ctl.fill_report;
        end
    end

    // hold the result fields one cycle with the strobe; a finished sweep reports a write
    always_ff @(posedge i_clk) begin
        if (ctl.fill_report) begin
            r_written   <= 1'b1;
            r_oor       <= 1'b0;
            r_color_out <= '0;
            r_depth_out <= '0;
        end else begin
            r_written   <= n_written;
            r_oor       <= n_oor;
            r_color_out <= n_color_out;
            r_depth_out <= n_depth_out;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_written      = r_written;
    assign o_out_of_range = r_oor;
    assign o_color_out    = r_color_out;
    assign o_depth_out    = r_depth_out;

    a_no_write_and_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_written && o_out_of_range))
        else $error("result both written and out of range");

    a_oor_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out_of_range) |-> (o_color_out == '0 && o_depth_out == '0))
        else $error("out-of-range result carries data");

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("not busy after accepting a transaction");

    a_depth_write_nearer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (depth_we && !ctl.fill_depth) |-> (r_depth <= rd_depth))
        else $error("depth written by a failing test");

endmodule

`default_nettype wire

// ----- sim/depth_tested_pixel_writer_tb.sv -----
`default_nettype none

module depth_tested_pixel_writer_tb;
    import dtpw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD_NS  = 4;
    localparam int          RESET_CYCLES    = 6;
    localparam int          TAIL_CYCLES     = 8;
    localparam int unsigned CYCLE_LIMIT     = 3_000_000;
    localparam int          MAX_REPORTS     = 10;
    localparam int          PHASES          = 8;
    localparam int          ITEMS_PER_PHASE = 64;
    localparam int          CALM_ITEMS      = 20;
    localparam int          HOT_PIXELS      = 4;
    localparam int unsigned CLEAR_AREA_MAX  = 1024;

    // op codes the block does not define; it must answer them with an all-zero result
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] color;
    } t_pixel_cmd;

    typedef struct packed {
        logic               written;
        logic               out_of_range;
        logic [COLOR_W-1:0] color;
        logic [DEPTH_W-1:0] depth;
    } t_pixel_resp;

    // DUT connections; every input holds a known value from time zero
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    i_op           = '0;
    logic [COORD_W-1:0] i_pixel_x      = '0;
    logic [COORD_W-1:0] i_pixel_y      = '0;
    logic [DEPTH_W-1:0] i_depth        = '0;
    logic [COLOR_W-1:0] i_color        = '0;
    logic               i_cfg_we       = 1'b0;
    logic               i_cfg_index    = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data     = '0;
    logic               o_strobe;
    logic               o_written;
    logic               o_out_of_range;
    logic [COLOR_W-1:0] o_color_out;
    logic [DEPTH_W-1:0] o_depth_out;

    // mirror of the frame buffer, depth buffer and frame registers
    logic [COLOR_W-1:0] color_mirror [STORE_SIZE];
    logic [DEPTH_W-1:0] depth_mirror [STORE_SIZE];
    logic [CFG_W-1:0]   frame_w_reg = WIDTH_CAP;
    logic [CFG_W-1:0]   frame_h_reg = HEIGHT_CAP;

    t_pixel_resp results_due [$];
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;

    depth_tested_pixel_writer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_depth        (i_depth),
        .i_color        (i_color),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_written      (o_written),
        .o_out_of_range (o_out_of_range),
        .o_color_out    (o_color_out),
        .o_depth_out    (o_depth_out)
    );

    always #HALF_PERIOD_NS i_clk = ~i_clk;

    // Bound the run; a hung handshake or a lost result ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("depth_tested_pixel_writer_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Frame mirror
    // ------------------------------------------------------------------

    // Clamp a frame register to the buffer's capacity.
    function automatic int unsigned clamp_span(input logic [CFG_W-1:0] value,
                                               input logic [CFG_W-1:0] cap);
        return (value > cap) ? cap : value;
    endfunction

    // Return the buffer address of a pixel, or -1 when it lies outside the active frame.
    function automatic int frame_addr(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        int unsigned w;
        int unsigned h;
        w = clamp_span(frame_w_reg, WIDTH_CAP);
        h = clamp_span(frame_h_reg, HEIGHT_CAP);
        if (x < w && y < h) begin
            return int'(y) * int'(w) + int'(x);
        end
        return -1;
    endfunction

    function automatic void fill_far_depth();
        for (int i = 0; i < STORE_SIZE; i++) begin
            depth_mirror[i] = DEPTH_FAR;
        end
    endfunction

    // Apply one command to the mirror and return the result the block owes for it.
    function automatic t_pixel_resp zbuffer_step(input t_pixel_cmd c);
        t_pixel_resp r;
        int          addr;
        int unsigned area;
        r    = '0;
        addr = frame_addr(c.x, c.y);
        case (c.op)
            OP_PLOT: begin
                if (addr < 0) begin
                    r.out_of_range = 1'b1;
                end else begin
                    color_mirror[addr] = c.color;
                    r.written          = 1'b1;
                end
            end
            OP_TEST_PLOT: begin
                // a tie replaces; a farther depth leaves both buffers alone
                if (addr < 0) begin
                    r.out_of_range = 1'b1;
                end else if (c.depth <= depth_mirror[addr]) begin
                    depth_mirror[addr] = c.depth;
                    color_mirror[addr] = c.color;
                    r.written          = 1'b1;
                end
            end
            OP_CLEAR_COLOR: begin
                area = clamp_span(frame_w_reg, WIDTH_CAP) * clamp_span(frame_h_reg, HEIGHT_CAP);
                for (int i = 0; i < area; i++) begin
                    color_mirror[i] = c.color;
                end
                r.written = 1'b1;
            end
            OP_RESET_DEPTH: begin
                fill_far_depth();
                r.written = 1'b1;
            end
            OP_READ: begin
                if (addr < 0) begin
                    r.out_of_range = 1'b1;
                end else begin
                    r.color = color_mirror[addr];
                    r.depth = depth_mirror[addr];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: inputs change on the falling edge, handshakes are seen on the rising edge
    // ------------------------------------------------------------------

    // Present one command and hold it until the block takes it; leave start high so that
    // a back-to-back transaction follows without a gap.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [DEPTH_W-1:0] depth,
                            input logic [COLOR_W-1:0] color);
        t_pixel_cmd c;
        c = '{op: op, x: x, y: y, depth: depth, color: color};
        @(negedge i_clk);
        start     <= 1'b1;
        i_op      <= c.op;
        i_pixel_x <= c.x;
        i_pixel_y <= c.y;
        i_depth   <= c.depth;
        i_color   <= c.color;
        do @(posedge i_clk); while (busy !== 1'b0);
        results_due.push_back(zbuffer_step(c));
    endtask

    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Drop start and hold off until every owed result has come and the block is idle.
    task automatic wait_drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (results_due.size() != 0 || busy !== 1'b0) @(negedge i_clk);
    endtask

    task automatic write_frame_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH) begin
            frame_w_reg = value;
        end else begin
            frame_h_reg = value;
        end
    endtask

    // Reprogram the frame only once the block has gone quiet.
    task automatic set_frame(input logic [CFG_W-1:0] width_value,
                             input logic [CFG_W-1:0] height_value);
        wait_drain();
        write_frame_reg(REG_FRAME_WIDTH, width_value);
        write_frame_reg(REG_FRAME_HEIGHT, height_value);
    endtask

    // ------------------------------------------------------------------
    // Result checker: one strobe per transaction, in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_pixel_resp want;
        if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            results_seen++;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result %0d arrived with no transaction outstanding", results_seen);
                end
            end else begin
                want = results_due.pop_front();
                if (o_written !== want.written || o_out_of_range !== want.out_of_range ||
                    o_color_out !== want.color || o_depth_out !== want.depth) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d: expected wr=%0b oor=%0b color=%08h depth=%06h",
                                 results_seen, want.written, want.out_of_range,
                                 want.color, want.depth);
                        $display("result %0d:      got wr=%0b oor=%0b color=%08h depth=%06h",
                                 results_seen, o_written, o_out_of_range,
                                 o_color_out, o_depth_out);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill the whole colour buffer first so no later read can hit an unwritten entry,
    // then confirm the post-reset sweep left the far depth at two opposite corners.
    task automatic test_depth_after_reset();
        send_cmd(OP_CLEAR_COLOR, '0, '0, '0, '0);
        send_cmd(OP_READ, '0, '0, '0, '0);
        send_cmd(OP_READ, '1, '1, '1, '1);
    endtask

    // Plot at the frame corners with extreme colours; a plain plot leaves depth untouched.
    task automatic test_plot_extremes();
        send_cmd(OP_PLOT, '1, '1, '0, '1);
        send_cmd(OP_PLOT, '0, '1, '1, 32'h8000_0000);
        send_cmd(OP_READ, '1, '1, '0, '0);
        send_cmd(OP_READ, '0, '1, '0, '0);
    endtask

    // Walk one pixel through far tie, nearer, farther, equal and zero depths.
    task automatic test_depth_compare();
        logic [COORD_W-1:0] px = 8'd10;
        logic [COORD_W-1:0] py = 8'd20;
        send_cmd(OP_TEST_PLOT, px, py, DEPTH_FAR, 32'h0000_0001);
        send_cmd(OP_TEST_PLOT, px, py, 24'h80_0000, 32'h0000_0002);
        send_cmd(OP_TEST_PLOT, px, py, 24'h80_0001, 32'h0000_0003);
        send_cmd(OP_TEST_PLOT, px, py, 24'h80_0000, 32'h0000_0004);
        send_cmd(OP_TEST_PLOT, px, py, '0, 32'h0000_0005);
        send_cmd(OP_READ, px, py, '0, '0);
    endtask

    // Depth reset covers the whole store; a colour clear covers only the active frame.
    task automatic test_clear_and_depth_reset();
        send_cmd(OP_RESET_DEPTH, '0, '0, '0, '0);
        send_cmd(OP_READ, 8'd10, 8'd20, '0, '0);
        set_frame(9'd7, 9'd3);
        send_cmd(OP_CLEAR_COLOR, '0, '0, '1, 32'h1234_5678);
        send_cmd(OP_READ, 8'd6, 8'd2, '0, '0);
        // one column past the right edge
        send_cmd(OP_READ, 8'd7, 8'd0, '0, '0);
    endtask

    // Zero-sized, oversized and single-pixel frames, plus the undefined op codes.
    task automatic test_frame_registers();
        set_frame(9'd0, 9'd5);
        send_cmd(OP_PLOT, '0, '0, '0, 32'hDEAD_BEEF);
        send_cmd(OP_CLEAR_COLOR, '0, '0, '0, 32'hDEAD_BEEF);
        set_frame('1, '1);
        send_cmd(OP_READ, '1, '1, '0, '0);
        set_frame(9'd1, 9'd1);
        send_cmd(OP_PLOT, 8'd1, 8'd0, '0, 32'h5555_AAAA);
        send_cmd(OP_TEST_PLOT, '0, '0, 24'd7, 32'h0F0F_0F0F);
        send_cmd(OP_UNUSED_FIRST, '1, '1, '1, '1);
        send_cmd(OP_UNUSED_LAST, '0, '0, '0, '0);
    endtask

    // Random traffic over several frame shapes. Coordinates cluster on a few hot pixels so
    // depth tests keep hitting earlier writes; depths are biased toward ties and nearer
    // values. The last phase runs back to back with no idling.
    task automatic test_random_traffic();
        logic [CFG_W-1:0]   width_value;
        logic [CFG_W-1:0]   height_value;
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DEPTH_W-1:0] z;
        logic [DEPTH_W-1:0] stored;
        logic [COORD_W-1:0] hot_x [HOT_PIXELS];
        logic [COORD_W-1:0] hot_y [HOT_PIXELS];
        int unsigned        w;
        int unsigned        h;
        int unsigned        pick;
        int unsigned        resets_left;
        int                 addr;
        int                 phase;
        int                 n;
        bit                 quiet;
        resets_left = 2;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin width_value = 9'd16;  height_value = 9'd16;  end
                1: begin width_value = 9'd1;   height_value = 9'd256; end
                2: begin width_value = 9'd256; height_value = 9'd1;   end
                3: begin width_value = 9'd7;   height_value = 9'd13;  end
                4: begin width_value = 9'd511; height_value = 9'd511; end
                5: begin width_value = 9'd300; height_value = 9'd3;   end
                6: begin width_value = 9'd0;   height_value = 9'd9;   end
                default: begin width_value = 9'd33; height_value = 9'd8; end
            endcase
            set_frame(width_value, height_value);
            w     = clamp_span(frame_w_reg, WIDTH_CAP);
            h     = clamp_span(frame_h_reg, HEIGHT_CAP);
            quiet = (phase == PHASES - 1);
            for (int j = 0; j < HOT_PIXELS; j++) begin
                hot_x[j] = (w != 0) ? COORD_W'($urandom_range(0, w - 1)) : '0;
                hot_y[j] = (h != 0) ? COORD_W'($urandom_range(0, h - 1)) : '0;
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // idle in bursts, after a calm opening stretch of each phase
                if (!quiet && n >= CALM_ITEMS && $urandom_range(0, 3) == 0) begin
                    idle_cycles($urandom_range(1, 11));
                end
                // drain completely mid-phase, and now and then at random
                if (!quiet && (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 39) == 0)) begin
                    wait_drain();
                end

                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    op = OP_PLOT;
                end else if (pick < 60) begin
                    op = OP_TEST_PLOT;
                end else if (pick < 85) begin
                    op = OP_READ;
                end else if (pick < 92) begin
                    // keep clears of large frames out of the random part; they cost a frame sweep
                    op = (w * h <= CLEAR_AREA_MAX) ? OP_CLEAR_COLOR : OP_READ;
                end else if (pick < 97) begin
                    op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
                end else if (resets_left != 0 && $urandom_range(0, 9) == 0) begin
                    op = OP_RESET_DEPTH;
                    resets_left--;
                end else begin
                    op = OP_TEST_PLOT;
                end

                pick = $urandom_range(0, 99);
                if (w == 0 || h == 0 || pick >= 88) begin
                    // anywhere in coordinate space, mostly outside small frames
                    x = COORD_W'($urandom);
                    y = COORD_W'($urandom);
                end else if (pick < 65) begin
                    pick = $urandom_range(0, HOT_PIXELS - 1);
                    x    = hot_x[pick];
                    y    = hot_y[pick];
                end else begin
                    x = COORD_W'($urandom_range(0, w - 1));
                    y = COORD_W'($urandom_range(0, h - 1));
                end

                addr   = frame_addr(x, y);
                stored = (addr >= 0) ? depth_mirror[addr] : DEPTH_FAR;
                pick   = $urandom_range(0, 99);
                if (pick < 30) begin
                    z = stored;
                end else if (pick < 60) begin
                    z = (stored == 0) ? '0 : DEPTH_W'($urandom_range(0, stored - 1));
                end else if (pick < 80) begin
                    z = DEPTH_W'($urandom);
                end else if (pick < 90) begin
                    z = '0;
                end else begin
                    z = DEPTH_FAR;
                end

                send_cmd(op, x, y, z, $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        fill_far_depth();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // the first transaction waits out the post-reset depth sweep through busy
        test_depth_after_reset();
        test_plot_extremes();
        test_depth_compare();
        test_clear_and_depth_reset();
        test_frame_registers();
        test_random_traffic();

        wait_drain();
        // give a stray strobe the chance to show up
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("depth_tested_pixel_writer_tb: done, clean");
        end else begin
            $display("depth_tested_pixel_writer_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
